### hw/rtl/dir_entry_name_search_top_defines.svh
// Shared assertion macros for the directory search block
`ifndef DIR_ENTRY_NAME_SEARCH_TOP_DEFINES_SVH
`define DIR_ENTRY_NAME_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define DESRCH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("directory search check failed");

// Next-cycle implication, checked through reset as well
`define DESRCH_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("directory search check failed");

`endif

### hw/rtl/desrch_pkg.sv
package desrch_pkg;

   // result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_END       = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [1:0] ST_BADLEN    = 2'd3;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_NAME = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_LEN  = 4'd1;

   // field widths
   localparam int LEN_W   = 4;
   localparam int INODE_W = 32;
   localparam int RECLEN_W = 16;

   // record header layout (byte offsets)
   localparam int OFF_RECLEN_LO = 4;
   localparam int OFF_RECLEN_HI = 5;
   localparam int OFF_NAMELEN   = 6;
   localparam int OFF_TYPE      = 7;
   localparam int HDR_BYTES     = 8;

   typedef struct packed {
      logic [1:0]         status;
      logic [INODE_W-1:0] inode;
      logic [7:0]         ftype;
   } rsp_type;

endpackage

### hw/rtl/dir_entry_name_search_top.sv
// Directory block name search, one byte per transaction.
// Throughput: one byte per cycle while the skid stage is empty; the per-byte
// record parser is a single combinational pass over the running record state.
// A status is registered in the output register, or in the skid one if stalled.
// Reset (synchronous, active high) clears the parser, target registers and
// the output and skid valid flags; the block is ready in the cycle after.
module dir_entry_name_search_top #(
   parameter int BLOCK_BYTES = 1024,
   parameter int NAME_BYTES  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte stream
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_block_last,
   // status
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [desrch_pkg::INODE_W-1:0]      rsp_found_inode,
   output logic [7:0]                          rsp_file_type,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [desrch_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [desrch_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int POS_W  = $clog2(BLOCK_BYTES + 1);
   localparam int SUM_W  = ((POS_W > desrch_pkg::RECLEN_W) ? POS_W : desrch_pkg::RECLEN_W) + 1;
   localparam int NAME_W = NAME_BYTES * 8;
   localparam int LEN_W  = desrch_pkg::LEN_W;

   // target registers
   logic [NAME_W-1:0] tname_ff;
   logic [LEN_W-1:0]  tlen_ff;

   // parser state
   logic [POS_W-1:0]                   byte_pos_ff, byte_pos_in;
   logic [POS_W-1:0]                   rec_start_ff, rec_start_in;
   logic [desrch_pkg::INODE_W-1:0]     inode_ff, inode_in;
   logic [desrch_pkg::RECLEN_W-1:0]    reclen_ff, reclen_in;
   logic [7:0]                         namelen_ff, namelen_in;
   logic [7:0]                         etype_ff, etype_in;
   logic                               mismatch_ff, mismatch_in;
   logic                               decided_ff, decided_in;

   // output register and skid stage
   logic                  out_valid_ff, out_valid_in;
   desrch_pkg::rsp_type   out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   desrch_pkg::rsp_type   skid_ff, skid_in;

   // per-byte working signals
   logic                  req_fire;
   logic                  active;
   logic [POS_W-1:0]      off;
   logic [LEN_W-1:0]      tlen_eff;
   logic [LEN_W-1:0]      cmp_cnt;
   logic                  byte_mis;
   logic                  rec_done;
   logic [SUM_W-1:0]      next_start;
   logic                  res_valid;
   desrch_pkg::rsp_type   res;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tname_ff <= '0;
         tlen_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            desrch_pkg::REG_TARGET_NAME: tname_ff <= csr_wdata[NAME_W-1:0];
            desrch_pkg::REG_TARGET_LEN:  tlen_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // compared length: min(name length, clamped target length)
   always_comb begin
      tlen_eff = (tlen_ff > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : tlen_ff;
      cmp_cnt  = (namelen_ff < 8'(tlen_eff)) ? namelen_ff[LEN_W-1:0] : tlen_eff;
   end

   assign active = !decided_ff
                && (byte_pos_ff < POS_W'(BLOCK_BYTES))
                && (rec_start_ff < POS_W'(BLOCK_BYTES))
                && (byte_pos_ff >= rec_start_ff);
   assign off = byte_pos_ff - rec_start_ff;

   // name byte compare against the target lane for this offset
   always_comb begin
      byte_mis = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if ((off == POS_W'(desrch_pkg::HDR_BYTES + i)) && (cmp_cnt > LEN_W'(i))
             && (tname_ff[8*i +: 8] != req_data_byte))
            byte_mis = 1'b1;
      end
   end

   assign rec_done   = (off >= POS_W'(desrch_pkg::OFF_TYPE) + POS_W'(cmp_cnt));
   assign next_start = SUM_W'(rec_start_ff) + SUM_W'(reclen_ff);

   // next parser state and result of this byte
   always_comb begin
      byte_pos_in  = byte_pos_ff;
      rec_start_in = rec_start_ff;
      inode_in     = inode_ff;
      reclen_in    = reclen_ff;
      namelen_in   = namelen_ff;
      etype_in     = etype_ff;
      mismatch_in  = mismatch_ff;
      decided_in   = decided_ff;
      res_valid    = 1'b0;
      res          = '0;

      if (req_fire) begin
         if (active) begin
            // header capture
            if (off == POS_W'(0)) begin
               inode_in    = {24'd0, req_data_byte};
               mismatch_in = 1'b0;
            end else if (off < POS_W'(desrch_pkg::OFF_RECLEN_LO)) begin
               inode_in[8*off[1:0] +: 8] = req_data_byte;
            end else if (off == POS_W'(desrch_pkg::OFF_RECLEN_LO)) begin
               reclen_in = {8'd0, req_data_byte};
            end else if (off == POS_W'(desrch_pkg::OFF_RECLEN_HI)) begin
               reclen_in[15:8] = req_data_byte;
            end else if (off == POS_W'(desrch_pkg::OFF_NAMELEN)) begin
               namelen_in = req_data_byte;
            end else if (off == POS_W'(desrch_pkg::OFF_TYPE)) begin
               etype_in = req_data_byte;
            end else begin
               mismatch_in = mismatch_ff | byte_mis;
            end

            // record end: decide or step to the next record
            if (rec_done) begin
               if (!mismatch_in) begin
                  res_valid  = 1'b1;
                  res.status = desrch_pkg::ST_FOUND;
                  res.inode  = inode_ff;
                  res.ftype  = etype_in;
                  decided_in = 1'b1;
               end else if (inode_ff == '0) begin
                  res_valid  = 1'b1;
                  res.status = desrch_pkg::ST_END;
                  decided_in = 1'b1;
               end else if (reclen_ff < desrch_pkg::RECLEN_W'(desrch_pkg::HDR_BYTES)
                                        + desrch_pkg::RECLEN_W'(cmp_cnt)) begin
                  res_valid  = 1'b1;
                  res.status = desrch_pkg::ST_BADLEN;
                  decided_in = 1'b1;
               end else begin
                  rec_start_in = (next_start > SUM_W'(BLOCK_BYTES)) ? POS_W'(BLOCK_BYTES)
                                                                    : next_start[POS_W-1:0];
                  mismatch_in  = 1'b0;
               end
            end
         end

         if (byte_pos_ff < POS_W'(BLOCK_BYTES))
            byte_pos_in = byte_pos_ff + POS_W'(1);

         // end of block: undecided gives exhausted, then restart
         if (req_block_last) begin
            if (!decided_in) begin
               res_valid  = 1'b1;
               res.status = desrch_pkg::ST_EXHAUSTED;
               res.inode  = '0;
               res.ftype  = '0;
            end
            byte_pos_in  = '0;
            rec_start_in = '0;
            inode_in     = '0;
            reclen_in    = '0;
            namelen_in   = '0;
            etype_in     = '0;
            mismatch_in  = 1'b0;
            decided_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         rec_start_ff <= '0;
         inode_ff     <= '0;
         reclen_ff    <= '0;
         namelen_ff   <= '0;
         etype_ff     <= '0;
         mismatch_ff  <= 1'b0;
         decided_ff   <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         rec_start_ff <= rec_start_in;
         inode_ff     <= inode_in;
         reclen_ff    <= reclen_in;
         namelen_ff   <= namelen_in;
         etype_ff     <= etype_in;
         mismatch_ff  <= mismatch_in;
         decided_ff   <= decided_in;
      end
   end

   // output register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_found_inode = out_ff.inode;
   assign rsp_file_type   = out_ff.ftype;

endmodule

### hw/rtl/desrch_checker.sv
`include "dir_entry_name_search_top_defines.svh"

// Port-level checks on the directory search block
module desrch_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic [desrch_pkg::INODE_W-1:0]     rsp_found_inode,
   input logic [7:0]                         rsp_file_type
);

   // no status transaction straight out of reset
   `DESRCH_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)

   // only a found status carries an inode or type
   `DESRCH_ASSERT_NOW(a_zero_unless_found, clock, reset,
      rsp_valid && (rsp_status != desrch_pkg::ST_FOUND),
      (rsp_found_inode == '0) && (rsp_file_type == '0))

   // stalled status transaction stays presented
   `DESRCH_ASSERT_NOW(a_stall_holds, clock, reset,
      $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid)

   // stalled status payload is unchanged
   `DESRCH_ASSERT_NOW(a_stall_stable, clock, reset,
      $past(rsp_valid && !rsp_ready) && !$past(reset),
      $stable(rsp_status) && $stable(rsp_found_inode) && $stable(rsp_file_type))

endmodule

bind dir_entry_name_search_top desrch_checker u_desrch_checker (.*);

### dv/dir_entry_name_search_top_tb.sv
module dir_entry_name_search_top_tb;

   localparam int BLOCK_SIZE  = 1024;
   localparam int NAME_MAX    = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 300;
   // index outside the register map, writes to it must be dropped
   localparam logic [desrch_pkg::CSR_IDX_W-1:0] REG_UNUSED = 4'hF;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } stream_byte_type;

   logic                              clock;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_ready;
   logic [7:0]                        req_data_byte  = '0;
   logic                              req_block_last = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready      = 1'b0;
   logic [1:0]                        rsp_status;
   logic [desrch_pkg::INODE_W-1:0]    rsp_found_inode;
   logic [7:0]                        rsp_file_type;
   logic                              csr_valid      = 1'b0;
   logic                              csr_ready;
   logic [desrch_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [desrch_pkg::CSR_DATA_W-1:0] csr_wdata      = '0;

   // stimulus side
   stream_byte_type byte_feed[$];
   logic [7:0]      blk_bytes[$];
   stream_byte_type next_byte;
   logic [63:0]     gen_name = '0;
   logic [3:0]      gen_len  = '0;
   bit              idle_on  = 1'b1;
   bit              hold_req = 1'b0;
   int              gap_left, stall_left, hold_left;

   // scan model state and its copy of the target registers
   desrch_pkg::rsp_type status_due[$];
   logic [63:0]  want_name;
   logic [3:0]   want_len;
   int           scan_pos, rec_base;
   logic [31:0]  ent_inode;
   logic [15:0]  ent_reclen;
   logic [7:0]   ent_namelen, ent_type;
   bit           name_diff, blk_done;

   // bookkeeping
   int cycle_count, err_count, bytes_seen, blocks_seen, settings_used;
   int status_seen[4];

   dir_entry_name_search_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_block_last  (req_block_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_inode (rsp_found_inode),
      .rsp_file_type   (rsp_file_type),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // name bytes actually compared for a record
   function automatic int cmp_bytes(input logic [7:0] namelen, input logic [3:0] len);
      int t;
      t = (len > NAME_MAX) ? NAME_MAX : int'(len);
      return (namelen < t) ? int'(namelen) : t;
   endfunction

   task automatic clear_scan();
      scan_pos    = 0;
      rec_base    = 0;
      ent_inode   = '0;
      ent_reclen  = '0;
      ent_namelen = '0;
      ent_type    = '0;
      name_diff   = 1'b0;
      blk_done    = 1'b0;
   endtask

   // advance the record parser by one byte, queue the status it decides
   task automatic scan_byte(input logic [7:0] b, input logic is_last);
      int                  off, cnt, nxt;
      desrch_pkg::rsp_type r;
      bit                  got;
      got = 1'b0;
      r   = '0;
      if (!blk_done && scan_pos < BLOCK_SIZE && rec_base < BLOCK_SIZE &&
          scan_pos >= rec_base) begin
         off = scan_pos - rec_base;
         if (off == 0) begin
            ent_inode = {24'd0, b};
            name_diff = 1'b0;
         end else if (off < desrch_pkg::OFF_RECLEN_LO) begin
            ent_inode[8*off +: 8] = b;
         end else if (off == desrch_pkg::OFF_RECLEN_LO) begin
            ent_reclen = {8'd0, b};
         end else if (off == desrch_pkg::OFF_RECLEN_HI) begin
            ent_reclen[15:8] = b;
         end else if (off == desrch_pkg::OFF_NAMELEN) begin
            ent_namelen = b;
         end else if (off == desrch_pkg::OFF_TYPE) begin
            ent_type = b;
         end else if (off - desrch_pkg::HDR_BYTES < cmp_bytes(ent_namelen, want_len)) begin
            if (want_name[8*(off-desrch_pkg::HDR_BYTES) +: 8] != b)
               name_diff = 1'b1;
         end

         // record decided once all compared name bytes are in
         cnt = cmp_bytes(ent_namelen, want_len);
         if (off >= desrch_pkg::OFF_TYPE + cnt) begin
            if (!name_diff) begin
               r = '{status: desrch_pkg::ST_FOUND, inode: ent_inode, ftype: ent_type};
               got = 1'b1;
            end else if (ent_inode == 0) begin
               r.status = desrch_pkg::ST_END;
               got = 1'b1;
            end else if (ent_reclen < desrch_pkg::HDR_BYTES + cnt) begin
               r.status = desrch_pkg::ST_BADLEN;
               got = 1'b1;
            end else begin
               nxt = rec_base + int'(ent_reclen);
               rec_base = (nxt > BLOCK_SIZE) ? BLOCK_SIZE : nxt;
               name_diff = 1'b0;
            end
            if (got)
               blk_done = 1'b1;
         end
      end

      if (scan_pos < BLOCK_SIZE)
         scan_pos++;

      if (is_last) begin
         if (!blk_done) begin
            r.status = desrch_pkg::ST_EXHAUSTED;
            got = 1'b1;
         end
         clear_scan();
      end
      if (got)
         status_due.push_back(r);
   endtask

   task automatic report_error(input string msg);
      err_count++;
      if (err_count <= 10)
         $display("MISMATCH @ cycle %0d: %s", cycle_count, msg);
   endtask

   // append one record to the block under construction
   task automatic add_record(input logic [31:0] inode, input logic [15:0] reclen,
                             input logic [7:0] namelen, input logic [7:0] ftype,
                             input bit hit, input int fill);
      int         cnt, flip;
      logic [7:0] nb;
      cnt  = cmp_bytes(namelen, gen_len);
      flip = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
      for (int i = 0; i < 4; i++)
         blk_bytes.push_back(inode[8*i +: 8]);
      blk_bytes.push_back(reclen[7:0]);
      blk_bytes.push_back(reclen[15:8]);
      blk_bytes.push_back(namelen);
      blk_bytes.push_back(ftype);
      for (int j = 0; j < fill; j++) begin
         nb = 8'($urandom_range(0, 255));
         if (j < cnt) begin
            nb = gen_name[8*j +: 8];
            if (!hit && j == flip)
               nb = nb ^ 8'($urandom_range(1, 255));
         end
         blk_bytes.push_back(nb);
      end
   endtask

   // hand the built bytes to the driver, optionally marking the block end
   task automatic close_block(input bit with_last);
      if (with_last && blk_bytes.size() == 0)
         blk_bytes.push_back(8'($urandom_range(0, 255)));
      foreach (blk_bytes[i])
         byte_feed.push_back('{value: blk_bytes[i],
                               is_last: with_last && (i == blk_bytes.size() - 1)});
      blk_bytes.delete();
   endtask

   // wait until every byte is taken and every status returned
   task automatic drain();
      @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || status_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [desrch_pkg::CSR_IDX_W-1:0] idx,
                            input logic [desrch_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_target(input logic [63:0] name, input logic [3:0] len);
      logic [63:0] junk;
      drain();
      junk = {$urandom, $urandom};
      write_reg(desrch_pkg::REG_TARGET_NAME, name);
      // only the low nibble counts, upper bits carry noise
      write_reg(desrch_pkg::REG_TARGET_LEN, (junk & ~64'hF) | 64'(len));
      gen_name = name;
      gen_len  = len;
      settings_used++;
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_feed.size() > 0) begin
            next_byte = byte_feed.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= next_byte.value;
            req_block_last <= next_byte.is_last;
            if (idle_on && $urandom_range(0, 9) == 0)
               gap_left = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: tracks register writes and bytes, checks statuses, drives rsp_ready
   always @(posedge clock) begin
      desrch_pkg::rsp_type exp_rsp;
      cycle_count++;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left  = 0;
         stall_left = 0;
         want_name  = '0;
         want_len   = '0;
         clear_scan();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               desrch_pkg::REG_TARGET_NAME: want_name = csr_wdata;
               desrch_pkg::REG_TARGET_LEN:  want_len  = csr_wdata[desrch_pkg::LEN_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            scan_byte(req_data_byte, req_block_last);
            bytes_seen++;
            if (req_block_last)
               blocks_seen++;
         end

         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report_error($sformatf("unexpected status %0d inode %08h type %02h",
                                      rsp_status, rsp_found_inode, rsp_file_type));
            end else begin
               exp_rsp = status_due.pop_front();
               if (rsp_status !== exp_rsp.status || rsp_found_inode !== exp_rsp.inode ||
                   rsp_file_type !== exp_rsp.ftype)
                  report_error($sformatf(
                     "expected status %0d inode %08h type %02h, got %0d %08h %02h",
                     exp_rsp.status, exp_rsp.inode, exp_rsp.ftype,
                     rsp_status, rsp_found_inode, rsp_file_type));
               status_seen[exp_rsp.status]++;
            end
         end

         // receiver back-pressure: one long hold-off on request, else short bursts
         if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0)
               stall_left = $urandom_range(1, 14);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("dir_entry_name_search_top test failed");
      $finish;
   end

   // stimulus
   initial begin
      int          cnt, body, fill, kind, nrec, cut;
      logic [7:0]  nl;
      logic [15:0] rl;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty target after reset: all-ones header matches at once
      repeat (8) blk_bytes.push_back(8'hFF);
      close_block(1'b1);
      // one-byte block, nothing decided
      blk_bytes.push_back(8'h00);
      close_block(1'b1);

      // oversized length acts as full name; zero inode entry with bad length ends scan
      set_target(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
      add_record(32'd0, 16'd0, 8'd1, 8'd0, 1'b0, 1);
      blk_bytes.push_back(8'hAB);
      close_block(1'b1);

      // target length raised in the middle of a record
      set_target({$urandom, $urandom}, 4'd2);
      add_record(32'd5, 16'd16, 8'd4, 8'd7, 1'b1, 1);
      close_block(1'b0);
      set_target(gen_name, 4'd4);
      blk_bytes.push_back(gen_name[15:8]);
      blk_bytes.push_back(gen_name[23:16]);
      blk_bytes.push_back(gen_name[31:24]);
      close_block(1'b1);

      // record length too short for the compared name
      add_record(32'h0000_1234, 16'd9, 8'd4, 8'd1, 1'b0, 4);
      close_block(1'b1);
      drain();
      write_reg(REG_UNUSED, {$urandom, $urandom});

      // random phases, one target setting each
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_target(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
            1: set_target(64'd0, 4'd15);
            2: set_target({$urandom, $urandom}, 4'd1);
            default: set_target({$urandom, $urandom}, 4'($urandom_range(0, 15)));
         endcase
         if (p == 7)
            idle_on = 1'b0;

         // long receiver hold-off while tiny blocks keep coming
         if (p == 4) begin
            @(negedge clock);
            hold_req = 1'b1;
            repeat (30) begin
               repeat ($urandom_range(1, 2)) blk_bytes.push_back(8'($urandom));
               close_block(1'b1);
            end
         end

         repeat (2) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               // noise block
               repeat ($urandom_range(1, 20)) blk_bytes.push_back(8'($urandom));
            end else begin
               nrec = $urandom_range(1, 2);
               repeat (nrec) begin
                  nl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 9));
                  cnt  = cmp_bytes(nl, gen_len);
                  kind = $urandom_range(0, 19);
                  if (kind == 0) begin
                     rl   = 16'($urandom_range(0, 7 + cnt));
                     fill = cnt + $urandom_range(0, 2);
                  end else if (kind == 1) begin
                     rl   = 16'($urandom_range(1100, 65535));
                     fill = cnt + 2;
                  end else begin
                     body = (nl > 12) ? 12 : int'(nl);
                     body = body + $urandom_range(0, 3);
                     rl   = 16'(desrch_pkg::HDR_BYTES + body);
                     fill = body;
                  end
                  add_record(($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom), rl, nl,
                             8'($urandom), $urandom_range(0, 3) == 0, fill);
               end
               // end-of-directory entry
               if ($urandom_range(0, 2) == 0) begin
                  nl = 8'($urandom_range(0, 9));
                  add_record(32'd0, 16'(desrch_pkg::HDR_BYTES + nl), nl, 8'($urandom),
                             $urandom_range(0, 3) == 0, nl);
               end
               repeat ($urandom_range(0, 3)) blk_bytes.push_back(8'($urandom));
               // occasionally cut the block short
               if ($urandom_range(0, 7) == 0) begin
                  cut = $urandom_range(1, blk_bytes.size());
                  while (blk_bytes.size() > cut)
                     void'(blk_bytes.pop_back());
               end
            end
            close_block(1'b1);
         end
         drain();
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Run covered %0d bytes in %0d blocks under %0d target settings,",
               bytes_seen, blocks_seen, settings_used);
      $display("  statuses found/end/exhausted/badlen = %0d/%0d/%0d/%0d, %0d mismatches",
               status_seen[desrch_pkg::ST_FOUND], status_seen[desrch_pkg::ST_END],
               status_seen[desrch_pkg::ST_EXHAUSTED], status_seen[desrch_pkg::ST_BADLEN],
               err_count);
      if (err_count == 0 && status_due.size() == 0)
         $display("dir_entry_name_search_top test passed");
      else
         $display("dir_entry_name_search_top test failed");
      $finish;
   end

endmodule
